[hdl/abd_pkg.sv]
// ============================================================================
// abd_pkg
// Shared types, constants and coefficient tables for the ADPCM block decoder.
// ============================================================================
package abd_pkg;

  // Block counter geometry
  localparam int BLOCKS_PER_HALF = 256;
  localparam int BLOCKS_PER_SUB  = 128;
  localparam int BLK_W = (BLOCKS_PER_HALF > 1) ? $clog2(BLOCKS_PER_HALF) : 1;
  localparam int SUB_W = (BLOCKS_PER_SUB > 1) ? $clog2(BLOCKS_PER_SUB) : 1;
  localparam logic [BLK_W:0] HALF_LIM = (BLK_W + 1)'(BLOCKS_PER_HALF);
  localparam logic [SUB_W:0] SUB_LIM  = (SUB_W + 1)'(BLOCKS_PER_SUB);

  // Byte positions inside a 16-byte block
  localparam logic [3:0] POS_HDR        = 4'd0;
  localparam logic [3:0] POS_FIRST_DATA = 4'd2;
  localparam logic [3:0] POS_LAST       = 4'd15;

  // Predictor clear modes
  localparam logic [1:0] MODE_CARRY = 2'd0;
  localparam logic [1:0] MODE_HALF  = 2'd1;
  localparam logic [1:0] MODE_SUB   = 2'd2;

  // Header decode limits
  localparam logic [3:0] FILTER_MAX = 4'd4;
  localparam logic [3:0] SHIFT_MAX  = 4'd12;
  localparam int         FRAC_BITS  = 6;

  // Datapath widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 8;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 26;
  localparam int RND_W    = ACC_W - FRAC_BITS;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [RND_W-1:0]    rnd_t;

  localparam rnd_t SAT_HI = rnd_t'(32767);
  localparam rnd_t SAT_LO = rnd_t'(-32768);

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LO,
    ST_HI
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic hdr_load;
    logic hist_clear;
    logic byte_load;
    logic step;
    logic step_hi;
  } cmd_t;

  // Weight of the newest sample, in 1/64 units
  function automatic coef_t coef_prev(input logic [2:0] filter);
    coef_t c;
    unique case (filter)
      3'd1:    c = coef_t'(60);
      3'd2:    c = coef_t'(115);
      3'd3:    c = coef_t'(98);
      3'd4:    c = coef_t'(122);
      default: c = coef_t'(0);
    endcase
    return c;
  endfunction

  // Weight of the older sample, in 1/64 units
  function automatic coef_t coef_older(input logic [2:0] filter);
    coef_t c;
    unique case (filter)
      3'd2:    c = coef_t'(-52);
      3'd3:    c = coef_t'(-55);
      3'd4:    c = coef_t'(-60);
      default: c = coef_t'(0);
    endcase
    return c;
  endfunction

endpackage

[hdl/abd_in_if.sv]
// ============================================================================
// abd_in_if
// Input channel: one stream byte per transfer, with a channel start mark.
// ============================================================================
interface abd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       channel_start;

  modport source (output valid, output data_byte, output channel_start, input ready);
  modport sink   (input valid, input data_byte, input channel_start, output ready);
endinterface

[hdl/abd_out_if.sv]
// ============================================================================
// abd_out_if
// Output channel: one decoded PCM sample per transfer.
// ============================================================================
interface abd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

[hdl/adpcm_block_decoder.sv]
// ============================================================================
// adpcm_block_decoder
// One-channel ADPCM block decoder: one stream byte in, two PCM samples out
// for each data byte of a 16-byte block.
// ============================================================================
//
//  channel   dir  payload                      transfer
//  --------  ---  ---------------------------  ------------------
//  in_ch     in   data_byte[7:0], channel_start valid && ready
//  out_ch    out  sample[15:0] signed, last     valid && ready
//  cfg       in   cfg_wdata_i[1:0] clear mode   cfg_we_i
//
//  A data byte takes one pass of the sample unit per nibble (ST_LO,
//  then ST_HI), since the second sample is predicted from the first.
//  Header bytes and byte 1 take no step and produce nothing.
//  The next byte is taken in the cycle of the high-nibble step, so a new data
//  byte goes in while the last one's high-nibble sample is made. A stalled
//  out_ch holds the sample unit; rst_ni at once clears control, header and history.
//
module adpcm_block_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  abd_in_if.sink     in_ch,
  abd_out_if.source  out_ch
);

  abd_pkg::cmd_t    cmd;
  abd_pkg::sample_t sample;
  logic             last;
  logic             in_ready;
  logic             out_valid;

  abd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_ch.valid),
    .in_start_i  (in_ch.channel_start),
    .in_ready_o  (in_ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  abd_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (in_ch.data_byte),
    .sample_o    (sample),
    .last_o      (last)
  );

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid;
  assign out_ch.sample = sample;
  assign out_ch.last   = last;

endmodule

[hdl/abd_ctrl.sv]
// ============================================================================
// abd_ctrl
// Sequencer: tracks block position and block counts, decides predictor
// clears and steps the datapath through the two nibbles of a data byte.
// ============================================================================
module abd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_start_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output abd_pkg::cmd_t     cmd_o
);

  abd_pkg::state_e state_q, state_d;
  logic [1:0]                 mode_q;
  logic [3:0]                 pos_q, pos_d;
  logic [abd_pkg::BLK_W-1:0]  blk_q, blk_d;
  logic [abd_pkg::SUB_W-1:0]  sub_q, sub_d;
  logic                       out_valid_q, out_valid_d;

  logic                       slot_free;
  logic                       step;
  logic                       accept;
  logic [3:0]                 pos_eff;
  logic [abd_pkg::BLK_W-1:0]  blk_eff;
  logic [abd_pkg::SUB_W-1:0]  sub_eff;
  logic                       is_hdr;
  logic                       is_data;
  logic [abd_pkg::BLK_W:0]    blk_inc;
  logic [abd_pkg::SUB_W:0]    sub_inc;
  logic                       mode_clear;

  // Output slot and byte position as the current transfer sees them
  assign slot_free = !out_valid_q || out_ready_i;
  assign step      = ((state_q == abd_pkg::ST_LO) || (state_q == abd_pkg::ST_HI)) && slot_free;
  assign accept    = in_valid_i && in_ready_o;
  assign pos_eff   = in_start_i ? abd_pkg::POS_HDR : pos_q;
  assign blk_eff   = in_start_i ? '0 : blk_q;
  assign sub_eff   = in_start_i ? '0 : sub_q;
  assign is_hdr    = (pos_eff == abd_pkg::POS_HDR);
  assign is_data   = (pos_eff >= abd_pkg::POS_FIRST_DATA);
  assign blk_inc   = {1'b0, blk_eff} + 1'b1;
  assign sub_inc   = {1'b0, sub_eff} + 1'b1;

  // Predictor clear at selected block boundaries
  assign mode_clear = ((mode_q == abd_pkg::MODE_HALF) && (blk_eff == '0)) ||
                      ((mode_q == abd_pkg::MODE_SUB) && (sub_eff == '0));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      abd_pkg::ST_IDLE: begin
        if (accept && is_data) state_d = abd_pkg::ST_LO;
      end
      abd_pkg::ST_LO: begin
        if (step) state_d = abd_pkg::ST_HI;
      end
      abd_pkg::ST_HI: begin
        if (step) state_d = (accept && is_data) ? abd_pkg::ST_LO : abd_pkg::ST_IDLE;
      end
      default: state_d = abd_pkg::ST_IDLE;
    endcase
  end

  // Handshake and datapath commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      abd_pkg::ST_IDLE: in_ready_o = 1'b1;
      abd_pkg::ST_LO:   in_ready_o = 1'b0;
      abd_pkg::ST_HI:   in_ready_o = slot_free;
      default:          in_ready_o = 1'b0;
    endcase
    cmd_o.step       = step;
    cmd_o.step_hi    = (state_q == abd_pkg::ST_HI);
    cmd_o.hdr_load   = accept && is_hdr;
    cmd_o.byte_load  = accept && is_data;
    cmd_o.hist_clear = accept && (in_start_i || (is_hdr && mode_clear));
  end

  // Advance byte position and block counters
  always_comb begin
    pos_d = pos_q;
    blk_d = blk_q;
    sub_d = sub_q;
    if (accept) begin
      pos_d = pos_eff + 4'd1;
      blk_d = blk_eff;
      sub_d = sub_eff;
      if (pos_eff == abd_pkg::POS_LAST) begin
        pos_d = abd_pkg::POS_HDR;
        if (blk_inc >= abd_pkg::HALF_LIM) begin
          blk_d = '0;
          sub_d = '0;
        end else begin
          blk_d = blk_inc[abd_pkg::BLK_W-1:0];
          sub_d = (sub_inc >= abd_pkg::SUB_LIM) ? '0 : sub_inc[abd_pkg::SUB_W-1:0];
        end
      end
    end
  end

  // Fill and drain the output slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abd_pkg::ST_IDLE;
      mode_q      <= abd_pkg::MODE_CARRY;
      pos_q       <= abd_pkg::POS_HDR;
      blk_q       <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      blk_q       <= blk_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[hdl/abd_dpath.sv]
// ============================================================================
// abd_dpath
// Sample datapath: header fields, predictor history and one shared unit that
// turns a nibble into a saturated 16-bit sample each step.
// ============================================================================
module abd_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abd_pkg::cmd_t     cmd_i,
  input  logic [7:0]        data_byte_i,
  output abd_pkg::sample_t  sample_o,
  output logic              last_o
);

  logic [3:0]        shift_q;
  logic [2:0]        filter_q;
  logic [7:0]        byte_q;
  abd_pkg::sample_t  prev_q;
  abd_pkg::sample_t  older_q;
  abd_pkg::sample_t  sample_q;
  logic              last_q;

  logic signed [3:0] nib;
  logic [3:0]        amt;
  logic [4:0]        sh;
  abd_pkg::coef_t    c_prev;
  abd_pkg::coef_t    c_older;
  abd_pkg::acc_t     term;
  abd_pkg::prod_t    p_prev;
  abd_pkg::prod_t    p_older;
  abd_pkg::acc_t     acc;
  abd_pkg::acc_t     acc_rnd;
  abd_pkg::rnd_t     rnd;
  abd_pkg::sample_t  sat;

  // Select nibble and scale it by the header shift
  assign nib  = cmd_i.step_hi ? byte_q[7:4] : byte_q[3:0];
  assign amt  = (shift_q <= abd_pkg::SHIFT_MAX) ? (abd_pkg::SHIFT_MAX - shift_q) : 4'd0;
  assign sh   = {1'b0, amt} + 5'(abd_pkg::FRAC_BITS);
  assign term = abd_pkg::acc_t'(nib) <<< sh;

  // Two-tap prediction
  assign c_prev  = abd_pkg::coef_prev(filter_q);
  assign c_older = abd_pkg::coef_older(filter_q);
  assign p_prev  = abd_pkg::prod_t'(prev_q) * abd_pkg::prod_t'(c_prev);
  assign p_older = abd_pkg::prod_t'(older_q) * abd_pkg::prod_t'(c_older);
  assign acc     = term + abd_pkg::acc_t'(p_prev) + abd_pkg::acc_t'(p_older);

  // Round half away from zero, then saturate
  assign acc_rnd = acc + (acc[abd_pkg::ACC_W-1] ? abd_pkg::acc_t'(31) : abd_pkg::acc_t'(32));
  assign rnd     = abd_pkg::rnd_t'(acc_rnd >>> abd_pkg::FRAC_BITS);

  always_comb begin
    if (rnd > abd_pkg::SAT_HI) begin
      sat = abd_pkg::sample_t'(abd_pkg::SAT_HI);
    end else if (rnd < abd_pkg::SAT_LO) begin
      sat = abd_pkg::sample_t'(abd_pkg::SAT_LO);
    end else begin
      sat = rnd[abd_pkg::SAMPLE_W-1:0];
    end
  end

  // Header fields and predictor history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '0;
      filter_q <= '0;
      prev_q   <= '0;
      older_q  <= '0;
    end else begin
      if (cmd_i.hdr_load) begin
        shift_q  <= data_byte_i[3:0];
        filter_q <= (data_byte_i[7:4] > abd_pkg::FILTER_MAX) ? 3'd0 : data_byte_i[6:4];
      end
      if (cmd_i.hist_clear) begin
        prev_q  <= '0;
        older_q <= '0;
      end else if (cmd_i.step) begin
        older_q <= prev_q;
        prev_q  <= sat;
      end
    end
  end

  // Hold data byte and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_load) begin
      byte_q <= data_byte_i;
    end
    if (cmd_i.step) begin
      sample_q <= sat;
      last_q   <= cmd_i.step_hi;
    end
  end

  assign sample_o = sample_q;
  assign last_o   = last_q;

endmodule

[hdl/abd_checker.sv]
// ============================================================================
// abd_checker
// Port-level checks on the decoder's output sequencing and stall behavior.
// ============================================================================
module abd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_last_i,
  input logic [15:0] out_sample_i
);

  // A low-nibble sample is followed at once by its high-nibble sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_last_i)
    else $error("high-nibble sample did not follow its low-nibble sample");

  // No new byte while a stalled low-nibble sample blocks the second step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while the high-nibble step is pending");

  // Hold output valid through a stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped without a transfer");

  // Hold output payload through a stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_sample_i) && $stable(out_last_i))
    else $error("output payload changed during a stall");

endmodule

bind adpcm_block_decoder abd_checker u_abd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_last_i   (out_ch.last),
  .out_sample_i (out_ch.sample)
);

[dv/abd_sample_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// abd_sample_checker
// Watches the byte and sample channels of the ADPCM block decoder, predicts
// the PCM samples of every accepted stream byte and compares them in order.
// ============================================================================
module abd_sample_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  abd_in_if          in_ch,
  abd_out_if         out_ch,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  typedef struct packed {
    abd_pkg::sample_t pcm;
    logic             hi_nib;
  } pcm_item_t;

  pcm_item_t  pcm_expect_q[$];

  // Predicted decoder state
  logic [1:0]       clear_mode;
  logic [3:0]       blk_pos;
  logic [7:0]       blk_idx;
  logic [3:0]       hdr_shift;
  logic [2:0]       hdr_filter;
  abd_pkg::sample_t hist_new;
  abd_pkg::sample_t hist_old;

  int         fails;
  int         checked;

  // Decode one nibble and advance the two-sample history
  function automatic abd_pkg::sample_t step_nibble(input logic [3:0] nib);
    longint acc;
    longint res;
    longint gain;
    int     w_new;
    int     w_old;
    case (hdr_filter)
      3'd1: begin
        w_new = 60;
        w_old = 0;
      end
      3'd2: begin
        w_new = 115;
        w_old = -52;
      end
      3'd3: begin
        w_new = 98;
        w_old = -55;
      end
      3'd4: begin
        w_new = 122;
        w_old = -60;
      end
      default: begin
        w_new = 0;
        w_old = 0;
      end
    endcase
    gain = (hdr_shift <= abd_pkg::SHIFT_MAX)
         ? (longint'(1) << (int'(abd_pkg::SHIFT_MAX) - int'(hdr_shift))) : 1;
    acc = longint'($signed(nib)) * gain * 64
        + longint'(hist_new) * w_new
        + longint'(hist_old) * w_old;
    // Round half away from zero, then saturate
    if (acc >= 0) begin
      res = (acc + 32) / 64;
    end else begin
      res = -((-acc + 32) / 64);
    end
    if (res > 32767) begin
      res = 32767;
    end
    if (res < -32768) begin
      res = -32768;
    end
    hist_old = hist_new;
    hist_new = abd_pkg::sample_t'(res);
    return abd_pkg::sample_t'(res);
  endfunction

  // Advance the predicted state by one stream byte
  task automatic take_byte(input logic [7:0] b, input logic open_ch);
    pcm_item_t lo;
    pcm_item_t hi;
    if (open_ch) begin
      blk_pos  = abd_pkg::POS_HDR;
      blk_idx  = '0;
      hist_new = '0;
      hist_old = '0;
    end
    if (blk_pos == abd_pkg::POS_HDR) begin
      if ((clear_mode == abd_pkg::MODE_HALF && blk_idx == 0) ||
          (clear_mode == abd_pkg::MODE_SUB &&
           (int'(blk_idx) % abd_pkg::BLOCKS_PER_SUB) == 0)) begin
        hist_new = '0;
        hist_old = '0;
      end
      hdr_shift  = b[3:0];
      hdr_filter = (b[7:4] > abd_pkg::FILTER_MAX) ? 3'd0 : b[6:4];
    end else if (blk_pos >= abd_pkg::POS_FIRST_DATA) begin
      lo.pcm    = step_nibble(b[3:0]);
      lo.hi_nib = 1'b0;
      pcm_expect_q.push_back(lo);
      hi.pcm    = step_nibble(b[7:4]);
      hi.hi_nib = 1'b1;
      pcm_expect_q.push_back(hi);
    end
    if (blk_pos == abd_pkg::POS_LAST) begin
      blk_pos = abd_pkg::POS_HDR;
      blk_idx = (int'(blk_idx) + 1 >= abd_pkg::BLOCKS_PER_HALF) ? 8'd0 : blk_idx + 8'd1;
    end else begin
      blk_pos = blk_pos + 4'd1;
    end
  endtask

  // Compare one sample transfer with the oldest prediction
  task automatic match_sample(input abd_pkg::sample_t got_pcm, input logic got_last);
    pcm_item_t want;
    if (pcm_expect_q.size() == 0) begin
      fails++;
      $display("%0t ERROR: unexpected sample %0d last=%0b, nothing pending",
               $time, got_pcm, got_last);
    end else begin
      want = pcm_expect_q.pop_front();
      checked++;
      if (got_pcm !== want.pcm) begin
        fails++;
        $display("%0t ERROR: sample expected %0d actual %0d",
                 $time, want.pcm, got_pcm);
      end
      if (got_last !== want.hi_nib) begin
        fails++;
        $display("%0t ERROR: last expected %0b actual %0b",
                 $time, want.hi_nib, got_last);
      end
    end
  endtask

  // Track transfers; outputs first so a result never matches its own byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcm_expect_q.delete();
      clear_mode   = abd_pkg::MODE_CARRY;
      blk_pos      = abd_pkg::POS_HDR;
      blk_idx      = '0;
      hdr_shift    = '0;
      hdr_filter   = '0;
      hist_new     = '0;
      hist_old     = '0;
      fails        = 0;
      checked      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        clear_mode = cfg_wdata_i;
      end
      if (out_ch.valid && out_ch.ready) begin
        match_sample(out_ch.sample, out_ch.last);
      end
      if (in_ch.valid && in_ch.ready) begin
        take_byte(in_ch.data_byte, in_ch.channel_start);
      end
      fail_count_o <= fails;
      pending_o    <= pcm_expect_q.size();
      checked_o    <= checked;
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Drives block streams with random pacing into the ADPCM block decoder,
// steps the predictor clear mode between phases and reports the verdict.
// ============================================================================
module tb_top;

  localparam int          IDLE_LIMIT    = 1000;
  localparam int          RANDOM_ITEMS  = 1400;
  localparam int          DRAIN_CYCLES  = 8;
  localparam logic [1:0]  MODE_SPARE    = 2'd3;  // undefined code, carries history

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;

  int         fail_count;
  int         pending;
  int         checked;
  int         bytes_sent;
  int         items_sent;
  bit         steady_run;

  abd_in_if  in_ch ();
  abd_out_if out_ch ();

  adpcm_block_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  abd_sample_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, none during steady runs
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_header();
    logic [3:0] filt;
    filt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(5, 15)) : 4'($urandom_range(0, 4));
    return {filt, 4'($urandom_range(0, 15))};
  endfunction

  // Bias some data bytes toward full-scale nibbles to reach the rails
  function automatic logic [7:0] rand_data();
    logic [7:0] edge_bytes[6];
    edge_bytes = '{8'h77, 8'h88, 8'h7F, 8'hF7, 8'h80, 8'h08};
    if ($urandom_range(0, 9) == 0) begin
      return edge_bytes[$urandom_range(0, 5)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Hold one byte until it transfers, then idle for a while
  task automatic push_byte(input logic [7:0] b, input logic open_ch, input bit skipped);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.channel_start <= open_ch;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_sent++;
    if (!skipped) begin
      items_sent++;
    end
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Header, byte 1, then n_data data bytes
  task automatic send_block(input bit open_ch, input int n_data);
    push_byte(rand_header(), open_ch, 1'b0);
    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    repeat (n_data) push_byte(rand_data(), 1'b0, 1'b0);
  endtask

  // Drop valid, wait for every predicted sample, then let the block go idle
  task automatic settle();
    in_ch.valid         <= 1'b0;
    in_ch.channel_start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Sample side pacing: runs of ready alternating with stalls of random length
  initial begin : sink_pacing
    int run_len;
    int hold_len;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_ch.ready <= 1'b1;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (run_len) @(posedge clk_i);
      out_ch.ready <= 1'b0;
      hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (hold_len) @(posedge clk_i);
    end
  end

  // End the run when nothing transfers for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst_ni === 1'b1);
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t timeout: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [1:0] phase_modes[5];
    int         phase;
    int         phase_end;
    int         target;
    int         r;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.channel_start = 1'b0;
    bytes_sent          = 0;
    items_sent          = 0;
    steady_run          = 1'b0;
    phase_modes         = '{abd_pkg::MODE_CARRY, abd_pkg::MODE_HALF, abd_pkg::MODE_SUB,
                            MODE_SPARE, abd_pkg::MODE_CARRY};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Filter 1, shift 0: zero, full-scale and sign-edge nibbles
    push_byte(8'h10, 1'b1, 1'b0);
    push_byte(8'hA5, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h77, 1'b0, 1'b0);
    push_byte(8'h88, 1'b0, 1'b0);
    // Filter 4, shift 0: push the sum into both rails
    push_byte(8'h40, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b1);
    repeat (3) push_byte(8'h77, 1'b0, 1'b0);
    repeat (3) push_byte(8'h88, 1'b0, 1'b0);
    // Filter code above four and shift above twelve
    push_byte(8'hFD, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h7F, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    // Filters 2 and 3 with the largest shift and one out of range
    push_byte(8'h2C, 1'b1, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b1);
    push_byte(8'h19, 1'b0, 1'b0);
    push_byte(8'h3E, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(8'hE1, 1'b0, 1'b0);

    // Random channels, one clear mode per phase
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      settle();
      write_mode((phase % 5 == 4) ? 2'($urandom_range(0, 3)) : phase_modes[phase % 5]);
      steady_run = ($urandom_range(0, 3) == 0);
      phase_end  = items_sent + $urandom_range(120, 260);
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_block(1'b1, 14);
          repeat ($urandom_range(0, 3)) send_block(1'b0, 14);
        end else if (r < 92) begin
          // channel cut short inside a block
          send_block(1'b1, $urandom_range(0, 13));
        end else begin
          // loose bytes, some restarting the channel mid-block
          repeat ($urandom_range(1, 6)) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
          end
        end
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d stream bytes and %0d compared samples,", bytes_sent, checked);
    $display("all four clear mode codes, channel restarts and blocks cut short.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
